// File: sv/fys_pkg.sv
// Package for the Fisher-Yates sampler: field widths, register indexes,
// controller states. No dependencies.
`timescale 1ns / 1ps

package fys_pkg;

	// Fixed field widths
	localparam int WORD_W   = 32;
	localparam int CNT_W    = 11;
	localparam int SAMPLE_W = 10;
	localparam int CFG_IDX_W = 2;

	// Epoch tag stored with each table entry; tag 0 marks a cleared entry
	localparam int EPOCH_W = 8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd1;

	// Controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_RD_POS,
		ST_RD_J,
		ST_WR_POS,
		ST_WR_J,
		ST_EMIT
	} fys_state_t;

endpackage

// File: sv/fys_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fys_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/fys_mod_unit.sv
// Bit-serial remainder unit: 32-bit word modulo an 11-bit divisor,
// one quotient bit per cycle. Depends on fys_pkg.
`timescale 1ns / 1ps

module fys_mod_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [fys_pkg::WORD_W-1:0] dividend,
	input  logic [fys_pkg::CNT_W-1:0]  divisor,
	output logic                       done,
	output logic [fys_pkg::CNT_W-1:0]  remainder
);

	localparam int STEP_W = $clog2(fys_pkg::WORD_W);

	logic                       busy_q;
	logic                       done_q;
	logic [STEP_W-1:0]          step_q;
	logic [fys_pkg::WORD_W-1:0] dvd_q;
	logic [fys_pkg::CNT_W-1:0]  dvs_q;
	logic [fys_pkg::CNT_W-1:0]  rem_q;

	logic [fys_pkg::CNT_W:0]    trial;
	logic [fys_pkg::CNT_W:0]    diff;
	logic [fys_pkg::CNT_W-1:0]  rem_next;

	// Restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial    = {rem_q, dvd_q[fys_pkg::WORD_W-1]};
		diff     = trial - {1'b0, dvs_q};
		rem_next = (trial >= {1'b0, dvs_q}) ? diff[fys_pkg::CNT_W-1:0]
		                                    : trial[fys_pkg::CNT_W-1:0];
	end

	// Control: busy while stepping through the dividend bits, then a one-cycle done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(fys_pkg::WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[fys_pkg::WORD_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// File: sv/fisher_yates_sampler_core.sv
// Top level of the Fisher-Yates sampler: controller, permutation table RAM,
// remainder unit and output register. Depends on fys_pkg, fys_ram, fys_mod_unit.
`timescale 1ns / 1ps

// Usage
//  - Input channel (in_valid/in_ready, random_word): one request per shuffle
//    step. Each request yields exactly one result on the output channel
//    (out_valid/out_ready, sample_value, round_last).
//  - Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data):
//    index 0 is range_size, index 1 is sample_count. Any write to either
//    starts a fresh round. Other indexes are ignored. Write only while idle.
//  - Each request taken passes through the bit-serial remainder unit (its
//    steps over the dividend bits and the done cycle), then two table reads
//    and two write-backs on the table RAM, then the output register. One
//    request is worked on at a time.
//  - The output register holds a finished result while out_ready is low; a
//    new request is still taken then, and its result waits in the
//    controller until the register frees up.
//  - Round restarts bump an epoch tag instead of rewriting the table. After
//    reset, and whenever the tag wraps (every 255 rounds), a clearing pass
//    writes every entry, with in_ready held low.

module fisher_yates_sampler_core #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input requests
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [fys_pkg::WORD_W-1:0]    random_word,
	// results
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [fys_pkg::SAMPLE_W-1:0]  sample_value,
	output logic                          round_last,
	// configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fys_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fys_pkg::CNT_W-1:0]     cfg_data
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int MW = fys_pkg::EPOCH_W + AW;
	localparam int WW = (AW > fys_pkg::CNT_W) ? AW : fys_pkg::CNT_W;
	localparam int VW = (AW > fys_pkg::SAMPLE_W) ? AW : fys_pkg::SAMPLE_W;
	localparam logic [fys_pkg::CNT_W-1:0] RANGE_MAX =
		(TABLE_DEPTH < 2047) ? fys_pkg::CNT_W'(TABLE_DEPTH) : '1;
	localparam logic [fys_pkg::EPOCH_W-1:0] EPOCH_MAX = '1;

	fys_pkg::fys_state_t state_q, state_d;

	// Configuration and round state
	logic [fys_pkg::CNT_W-1:0]   range_q;
	logic [fys_pkg::CNT_W-1:0]   samples_q;
	logic [fys_pkg::CNT_W-1:0]   cd_q;
	logic [fys_pkg::CNT_W-1:0]   emitted_q;
	logic [fys_pkg::EPOCH_W-1:0] epoch_q;
	logic [AW-1:0]               clr_q;

	// Per-item registers
	logic [fys_pkg::CNT_W-1:0]   k_q;
	logic [AW-1:0]               pos_q;
	logic [AW-1:0]               j_q;
	logic [AW-1:0]               val_pos_q;
	logic [AW-1:0]               val_j_q;

	// Output register
	logic                          out_valid_q;
	logic [fys_pkg::SAMPLE_W-1:0]  sample_value_q;
	logic                          round_last_q;

	// Derived signals
	logic [fys_pkg::CNT_W-1:0] eff_range;
	logic [fys_pkg::CNT_W-1:0] eff_samples;
	logic [fys_pkg::CNT_W-1:0] samp_nz;
	logic [fys_pkg::CNT_W-1:0] k_d;
	logic [fys_pkg::CNT_W-1:0] cd_next;
	logic [fys_pkg::CNT_W-1:0] emitted_next;
	logic [WW-1:0]             pos_w;
	logic [WW-1:0]             j_w;
	logic [VW-1:0]             val_ext;
	logic                      last;
	logic                      in_fire;
	logic                      cfg_fire;
	logic                      cfg_hit;
	logic                      emit_fire;
	logic                      restart;
	logic                      clear_done;

	// Remainder unit
	logic                      mod_done;
	logic [fys_pkg::CNT_W-1:0] mod_rem;

	// Table RAM
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [MW-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [MW-1:0] ram_rdata;
	logic [AW-1:0] rd_val;

	// Effective range and sample count
	always_comb begin
		if (range_q == '0) begin
			eff_range = fys_pkg::CNT_W'(1);
		end else if (range_q > RANGE_MAX) begin
			eff_range = RANGE_MAX;
		end else begin
			eff_range = range_q;
		end
		samp_nz     = (samples_q == '0) ? fys_pkg::CNT_W'(1) : samples_q;
		eff_samples = (samp_nz > eff_range) ? eff_range : samp_nz;
	end

	// Step setup and round bookkeeping
	always_comb begin
		k_d          = (cd_q == '0 || cd_q > eff_range) ? eff_range : cd_q;
		cd_next      = k_q - 1'b1;
		emitted_next = emitted_q + 1'b1;
		last         = (emitted_next >= eff_samples) || (cd_next == '0);
		pos_w        = WW'(k_q) - 1'b1;
		j_w          = WW'(mod_rem);
		val_ext      = VW'(val_j_q);
	end

	// Handshakes
	assign cfg_ready  = 1'b1;
	assign in_ready   = (state_q == fys_pkg::ST_IDLE) && !cfg_valid;
	assign in_fire    = in_valid && in_ready;
	assign cfg_fire   = cfg_valid && cfg_ready;
	assign cfg_hit    = cfg_fire && (cfg_index == fys_pkg::REG_RANGE_SIZE ||
	                                 cfg_index == fys_pkg::REG_SAMPLE_COUNT);
	assign emit_fire  = (state_q == fys_pkg::ST_EMIT) && (!out_valid_q || out_ready);
	assign restart    = cfg_hit || (emit_fire && last);
	assign clear_done = (state_q == fys_pkg::ST_CLEAR) && (clr_q == AW'(TABLE_DEPTH - 1));

	// A stale epoch tag means the entry still holds its identity value
	assign rd_val = (ram_rdata[MW-1:AW] == epoch_q) ? ram_rdata[AW-1:0]
	              : ((state_q == fys_pkg::ST_RD_J) ? pos_q : j_q);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fys_pkg::ST_CLEAR: begin
				if (clear_done) begin
					state_d = fys_pkg::ST_IDLE;
				end
			end
			fys_pkg::ST_IDLE: begin
				if (cfg_hit && epoch_q == EPOCH_MAX) begin
					state_d = fys_pkg::ST_CLEAR;
				end else if (in_fire) begin
					state_d = fys_pkg::ST_DIV;
				end
			end
			fys_pkg::ST_DIV: begin
				if (mod_done) begin
					state_d = fys_pkg::ST_RD_POS;
				end
			end
			fys_pkg::ST_RD_POS: state_d = fys_pkg::ST_RD_J;
			fys_pkg::ST_RD_J:   state_d = fys_pkg::ST_WR_POS;
			fys_pkg::ST_WR_POS: state_d = fys_pkg::ST_WR_J;
			fys_pkg::ST_WR_J:   state_d = fys_pkg::ST_EMIT;
			fys_pkg::ST_EMIT: begin
				if (emit_fire) begin
					state_d = (last && epoch_q == EPOCH_MAX) ? fys_pkg::ST_CLEAR
					                                         : fys_pkg::ST_IDLE;
				end
			end
			default: state_d = fys_pkg::ST_CLEAR;
		endcase
	end

	// RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		ram_raddr = pos_q;
		unique case (state_q)
			fys_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			fys_pkg::ST_RD_POS: ram_raddr = pos_q;
			fys_pkg::ST_RD_J:   ram_raddr = j_q;
			fys_pkg::ST_WR_POS: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q;
				ram_wdata = {epoch_q, rd_val};
			end
			fys_pkg::ST_WR_J: begin
				ram_we    = 1'b1;
				ram_waddr = j_q;
				ram_wdata = {epoch_q, val_pos_q};
			end
			fys_pkg::ST_IDLE, fys_pkg::ST_DIV, fys_pkg::ST_EMIT: begin
				ram_we = 1'b0;
			end
			default: ram_we = 1'b0;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fys_pkg::ST_CLEAR;
			range_q     <= fys_pkg::CNT_W'(1024);
			samples_q   <= fys_pkg::CNT_W'(1);
			cd_q        <= '0;
			emitted_q   <= '0;
			epoch_q     <= fys_pkg::EPOCH_W'(1);
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_fire && cfg_index == fys_pkg::REG_RANGE_SIZE) begin
				range_q <= cfg_data;
			end
			if (cfg_fire && cfg_index == fys_pkg::REG_SAMPLE_COUNT) begin
				samples_q <= cfg_data;
			end

			// Round counters; a countdown of zero reloads from the range
			if (restart) begin
				cd_q      <= '0;
				emitted_q <= '0;
			end else if (emit_fire) begin
				cd_q      <= cd_next;
				emitted_q <= emitted_next;
			end

			// Epoch advance, or clearing pass when the tag runs out
			if (clear_done) begin
				epoch_q <= fys_pkg::EPOCH_W'(1);
			end else if (restart && state_q != fys_pkg::ST_CLEAR && epoch_q != EPOCH_MAX) begin
				epoch_q <= epoch_q + 1'b1;
			end

			if (state_q == fys_pkg::ST_CLEAR) begin
				clr_q <= clear_done ? '0 : clr_q + 1'b1;
			end

			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Per-item datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			k_q <= k_d;
		end
		if (state_q == fys_pkg::ST_DIV && mod_done) begin
			pos_q <= pos_w[AW-1:0];
			j_q   <= j_w[AW-1:0];
		end
		if (state_q == fys_pkg::ST_RD_J) begin
			val_pos_q <= rd_val;
		end
		if (state_q == fys_pkg::ST_WR_POS) begin
			val_j_q <= rd_val;
		end
		if (emit_fire) begin
			sample_value_q <= val_ext[fys_pkg::SAMPLE_W-1:0];
			round_last_q   <= last;
		end
	end

	fys_mod_unit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_fire),
		.dividend  (random_word),
		.divisor   (k_d),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	fys_ram #(
		.WIDTH (MW),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign out_valid    = out_valid_q;
	assign sample_value = sample_value_q;
	assign round_last   = round_last_q;

endmodule

// File: sv/fys_checker.sv
// Port-level checker for the Fisher-Yates sampler, bound to the top level.
// Depends on fys_pkg and fisher_yates_sampler_core.
`timescale 1ns / 1ps

module fys_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [fys_pkg::SAMPLE_W-1:0]  sample_value,
	input logic                          round_last
);

	// Requests taken but whose results are not yet delivered
	logic [1:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
		end
	end

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_value) && $stable(round_last))
		else $error("stalled result changed");

	// One request at a time: no back-to-back accepts
	a_no_b2b: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted in consecutive cycles");

	// Never a result without a request behind it
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result without a pending request");

	// Input is taken only when at most one result is still owed
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> pend_q <= 2'd1)
		else $error("too many pending requests");

endmodule

bind fisher_yates_sampler_core fys_checker u_fys_checker (.*);
